// ===== hw/rtl/wws_pkg.sv =====
// Weather window statistics: shared types, field widths, register indexes
// and reset values. No dependencies.
package wws_pkg;

  localparam int TIME_W  = 32;
  localparam int WIN_W   = 16;
  localparam int LIMIT_W = 14;
  localparam int FLAGS_W = 7;
  localparam int TEMP_W  = 15;
  localparam int HUM_W   = 7;
  localparam int WS_W    = 14;
  localparam int WD_W    = 16;
  localparam int GUST_W  = 14;
  localparam int PRES_W  = 15;
  localparam int NUM_WIN = 6;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 128;
  localparam int IN_USER_W  = 8;
  localparam int OUT_DATA_W = 96;
  localparam int OUT_USER_W = 8;

  // valid_flags bit positions
  localparam int FLAG_TEMP     = 0;
  localparam int FLAG_HUM      = 1;
  localparam int FLAG_WIND     = 2;
  localparam int FLAG_GUST     = 3;
  localparam int FLAG_RAIN     = 4;
  localparam int FLAG_INSIDE   = 5;
  localparam int FLAG_PRESSURE = 6;

  // window slots (same order as the window registers)
  localparam int WIN_TEMP   = 0;
  localparam int WIN_INSIDE = 1;
  localparam int WIN_HUM    = 2;
  localparam int WIN_WIND   = 3;
  localparam int WIN_GUST   = 4;
  localparam int WIN_PRES   = 5;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_TEMP_WIN     = 3'd0,
    REG_INSIDE_WIN   = 3'd1,
    REG_HUM_WIN      = 3'd2,
    REG_WIND_WIN     = 3'd3,
    REG_GUST_WIN     = 3'd4,
    REG_PRES_WIN     = 3'd5,
    REG_GUST_LIMIT   = 3'd6
  } cfg_reg_t;

  localparam logic [WIN_W-1:0]   WIN_RESET_DEFAULT = 16'd300;
  localparam logic [WIN_W-1:0]   WIN_RESET_GUST    = 16'd600;
  localparam logic [LIMIT_W-1:0] GUST_LIMIT_RESET  = 14'd4470;

  // tdata layouts, first field in the highest bits
  typedef struct packed {
    logic [PRES_W-1:0]        pressure_sample;
    logic [GUST_W-1:0]        gust_sample;
    logic [WD_W-1:0]          wind_dir_sample;
    logic [WS_W-1:0]          wind_speed_sample;
    logic [HUM_W-1:0]         humidity_sample;
    logic signed [TEMP_W-1:0] inside_temp_sample;
    logic signed [TEMP_W-1:0] temp_sample;
    logic [TIME_W-1:0]        now_seconds;
  } in_item_t;

  typedef struct packed {
    logic [PRES_W-1:0]        min_pressure;
    logic [GUST_W-1:0]        max_gust;
    logic [WD_W-1:0]          avg_wind_dir;
    logic [WS_W-1:0]          avg_wind_speed;
    logic [HUM_W-1:0]         avg_humidity;
    logic signed [TEMP_W-1:0] avg_inside_temp;
    logic signed [TEMP_W-1:0] avg_temp;
  } out_item_t;

  typedef struct packed {
    logic [FLAGS_W-1:0] flags_out;
    logic               gust_rejected;
  } out_user_t;

endpackage

// ===== hw/rtl/wws_window.sv =====
// One time window: start register and 33-bit expiry compare.
// Depends on wws_pkg.
module wws_window (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic [wws_pkg::TIME_W-1:0] now,
  input  logic [wws_pkg::WIN_W-1:0]  win,
  output logic                      expired
);
  import wws_pkg::*;

  logic [TIME_W-1:0] start_r;
  logic [TIME_W:0]   end_time;

  assign end_time = {1'b0, start_r} + {{(TIME_W+1-WIN_W){1'b0}}, win};
  assign expired  = {1'b0, now} > end_time;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
    end else if (en && expired) begin
      start_r <= now;
    end
  end

endmodule

// ===== hw/rtl/weather_window_stats_core.sv =====
// Weather window statistics top level: input register, single-pass update
// of averages, gust maximum and pressure minimum, result register.
// Depends on wws_pkg and wws_window.
//
//   channel | ports       | beat
//   --------+-------------+---------------------------------------------
//   input   | in_t*       | sensor frame, valid flags in tuser
//   result  | out_t*      | averages and extremes, reject flag in tuser
//   config  | cfg_*       | window lengths and gust limit, one write
//
// One beat per cycle sustained while the result side accepts; an input beat passes
// the input register, then the result register with all state updated together.
// Reset clears the averages, extremes and window starts and reloads the
// register defaults. A stalled result holds while one further beat waits
// in the input register.
module weather_window_stats_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // now_seconds, temp_sample, inside_temp_sample, humidity_sample,
  // wind_speed_sample, wind_dir_sample, gust_sample, pressure_sample
  input  logic [wws_pkg::IN_DATA_W-1:0]  in_tdata,
  // valid_flags, zero pad
  input  logic [wws_pkg::IN_USER_W-1:0]  in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // avg_temp, avg_inside_temp, avg_humidity, avg_wind_speed,
  // avg_wind_dir, max_gust, min_pressure
  output logic [wws_pkg::OUT_DATA_W-1:0] out_tdata,
  // gust_rejected, flags_out
  output logic [wws_pkg::OUT_USER_W-1:0] out_tuser,
  input  logic                          cfg_wr_en,
  input  logic [wws_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [wws_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import wws_pkg::*;

  logic [WIN_W-1:0]   win_r [NUM_WIN];
  logic [LIMIT_W-1:0] gust_limit_r;

  logic               s1_v_r;
  in_item_t           s1_item_r;
  logic [FLAGS_W-1:0] s1_flags_r;
  logic               out_v_r;
  out_item_t          out_item_r;
  out_user_t          out_user_r;

  logic signed [TEMP_W-1:0] temp_avg_r, temp_avg_nxt;
  logic signed [TEMP_W-1:0] inside_avg_r, inside_avg_nxt;
  logic [HUM_W-1:0]         hum_avg_r, hum_avg_nxt;
  logic [WS_W-1:0]          ws_avg_r, ws_avg_nxt;
  logic [WD_W-1:0]          wd_avg_r, wd_avg_nxt;
  logic [GUST_W-1:0]        gust_max_r, gust_max_nxt;
  logic [PRES_W-1:0]        pres_min_r, pres_min_nxt;

  logic                adv;
  logic [NUM_WIN-1:0]  win_en;
  logic [NUM_WIN-1:0]  win_exp;
  logic [FLAGS_W-1:0]  f;
  logic                gust_rej;
  logic                gust_upd;
  logic                pres_upd;

  logic signed [TEMP_W-1:0] temp_old, inside_old;
  logic signed [TEMP_W:0]   temp_sum, inside_sum;
  logic [HUM_W-1:0]         hum_old;
  logic [HUM_W:0]           hum_sum;
  logic [WS_W-1:0]          ws_old;
  logic [WS_W:0]            ws_sum;
  logic [WD_W-1:0]          wd_old;
  logic [WD_W:0]            wd_sum;
  logic [GUST_W-1:0]        gust_old;
  logic [PRES_W-1:0]        pres_old;

  assign adv       = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !s1_v_r || adv;
  assign f         = s1_flags_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_WIN; i++) begin
        win_r[i] <= (i == WIN_GUST) ? WIN_RESET_GUST : WIN_RESET_DEFAULT;
      end
      gust_limit_r    <= GUST_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_TEMP_WIN:   win_r[WIN_TEMP]   <= cfg_wdata;
        REG_INSIDE_WIN: win_r[WIN_INSIDE] <= cfg_wdata;
        REG_HUM_WIN:    win_r[WIN_HUM]    <= cfg_wdata;
        REG_WIND_WIN:   win_r[WIN_WIND]   <= cfg_wdata;
        REG_GUST_WIN:   win_r[WIN_GUST]   <= cfg_wdata;
        REG_PRES_WIN:   win_r[WIN_PRES]   <= cfg_wdata;
        REG_GUST_LIMIT: gust_limit_r      <= cfg_wdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_item_r  <= in_tdata;
      s1_flags_r <= in_tuser[FLAGS_W-1:0];
    end
  end

  // windows
  assign gust_rej = f[FLAG_GUST] && (s1_item_r.gust_sample > gust_limit_r);
  assign gust_upd = f[FLAG_GUST] && !gust_rej;
  assign pres_upd = f[FLAG_PRESSURE] && !gust_rej;

  always_comb begin
    win_en             = '0;
    win_en[WIN_TEMP]   = adv && f[FLAG_TEMP];
    win_en[WIN_INSIDE] = adv && f[FLAG_INSIDE];
    win_en[WIN_HUM]    = adv && f[FLAG_HUM];
    win_en[WIN_WIND]   = adv && f[FLAG_WIND];
    win_en[WIN_GUST]   = adv && gust_upd;
    win_en[WIN_PRES]   = adv && pres_upd;
  end

  for (genvar g = 0; g < NUM_WIN; g++) begin : g_win
    wws_window u_win (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (win_en[g]),
      .now     (s1_item_r.now_seconds),
      .win     (win_r[g]),
      .expired (win_exp[g])
    );
  end

  // update
  always_comb begin
    temp_old = (win_exp[WIN_TEMP] || temp_avg_r == '0) ? s1_item_r.temp_sample : temp_avg_r;
    temp_sum = {temp_old[TEMP_W-1], temp_old}
             + {s1_item_r.temp_sample[TEMP_W-1], s1_item_r.temp_sample};
    temp_avg_nxt = f[FLAG_TEMP] ? temp_sum[TEMP_W:1] : temp_avg_r;

    inside_old = (win_exp[WIN_INSIDE] || inside_avg_r == '0)
               ? s1_item_r.inside_temp_sample : inside_avg_r;
    inside_sum = {inside_old[TEMP_W-1], inside_old}
               + {s1_item_r.inside_temp_sample[TEMP_W-1], s1_item_r.inside_temp_sample};
    inside_avg_nxt = f[FLAG_INSIDE] ? inside_sum[TEMP_W:1] : inside_avg_r;

    hum_old = (win_exp[WIN_HUM] || hum_avg_r == '0) ? s1_item_r.humidity_sample : hum_avg_r;
    hum_sum = {1'b0, hum_old} + {1'b0, s1_item_r.humidity_sample};
    hum_avg_nxt = f[FLAG_HUM] ? hum_sum[HUM_W:1] : hum_avg_r;

    ws_old = (win_exp[WIN_WIND] || ws_avg_r == '0) ? s1_item_r.wind_speed_sample : ws_avg_r;
    ws_sum = {1'b0, ws_old} + {1'b0, s1_item_r.wind_speed_sample};
    ws_avg_nxt = f[FLAG_WIND] ? ws_sum[WS_W:1] : ws_avg_r;

    wd_old = (win_exp[WIN_WIND] || wd_avg_r == '0) ? s1_item_r.wind_dir_sample : wd_avg_r;
    wd_sum = {1'b0, wd_old} + {1'b0, s1_item_r.wind_dir_sample};
    wd_avg_nxt = f[FLAG_WIND] ? wd_sum[WD_W:1] : wd_avg_r;

    gust_old = win_exp[WIN_GUST] ? '0 : gust_max_r;
    if (!gust_upd) begin
      gust_max_nxt = gust_max_r;
    end else if (s1_item_r.gust_sample > gust_old) begin
      gust_max_nxt = s1_item_r.gust_sample;
    end else begin
      gust_max_nxt = gust_old;
    end

    pres_old = win_exp[WIN_PRES] ? '0 : pres_min_r;
    if (!pres_upd) begin
      pres_min_nxt = pres_min_r;
    end else if (pres_old == '0 || s1_item_r.pressure_sample < pres_old) begin
      pres_min_nxt = s1_item_r.pressure_sample;
    end else begin
      pres_min_nxt = pres_old;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_avg_r   <= '0;
      inside_avg_r <= '0;
      hum_avg_r    <= '0;
      ws_avg_r     <= '0;
      wd_avg_r     <= '0;
      gust_max_r   <= '0;
      pres_min_r   <= '0;
    end else if (adv) begin
      temp_avg_r   <= temp_avg_nxt;
      inside_avg_r <= inside_avg_nxt;
      hum_avg_r    <= hum_avg_nxt;
      ws_avg_r     <= ws_avg_nxt;
      wd_avg_r     <= wd_avg_nxt;
      gust_max_r   <= gust_max_nxt;
      pres_min_r   <= pres_min_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item_r.avg_temp        <= temp_avg_nxt;
      out_item_r.avg_inside_temp <= inside_avg_nxt;
      out_item_r.avg_humidity    <= hum_avg_nxt;
      out_item_r.avg_wind_speed  <= ws_avg_nxt;
      out_item_r.avg_wind_dir    <= wd_avg_nxt;
      out_item_r.max_gust        <= gust_max_nxt;
      out_item_r.min_pressure    <= pres_min_nxt;
      out_user_r.gust_rejected   <= gust_rej;
      out_user_r.flags_out       <= f & ~(FLAGS_W'(gust_rej) << FLAG_GUST);
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_item_r;
  assign out_tuser  = out_user_r;

endmodule

// ===== hw/rtl/wws_checker.sv =====
// Port-level checks for weather_window_stats_core, bound to the top level.
// Depends on wws_pkg.
module wws_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [wws_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [wws_pkg::OUT_USER_W-1:0] out_tuser
);
  import wws_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while result side drains");

  a_reject_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> !out_tuser[1 + FLAG_GUST])
    else $error("gust flag kept on rejected frame");

endmodule

bind weather_window_stats_core wws_checker u_wws_checker (.*);
